// ----- src/ps2mt_pkg.sv -----
// Shared constants, codes and types of the PS/2 mouse packet tracker.
package ps2mt_pkg;

   // Position width and ring depth.
   localparam int COORD_BITS  = 12;
   localparam int QUEUE_DEPTH = 32;

   // Depth of the command queue between the front and the back.
   localparam int CMDQ_DEPTH = 2;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLED = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_X   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_Y   = 2'd2;

   // Reset values of the limits and of the position.
   localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(1023);
   localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(767);
   localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(512);
   localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(384);

   // Request kinds.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Status byte bits.
   localparam int STATUS_SYNC_BIT  = 3;
   localparam int STATUS_X_OVF_BIT = 6;
   localparam int STATUS_Y_OVF_BIT = 7;

   // One queued event: dy, dx, status from high to low.
   localparam int EVENT_BITS = 24;

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      OP_NOP  = 2'd0,
      OP_POP  = 2'd1,
      OP_PUSH = 2'd2
   } op_type;

   typedef struct packed {
      op_type   op;
      byte_type status;
      byte_type dx;
      byte_type dy;
   } cmd_type;

   typedef struct packed {
      logic                  enabled;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] max_y;
   } cfg_type;

endpackage

// ----- src/ps2mt_req_if.sv -----
// Request channel: a controller byte or a pop request.
interface ps2mt_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic       from_aux;
   logic [7:0] data_byte;

   modport source (output valid, req_type, from_aux, data_byte, input ready);
   modport sink   (input valid, req_type, from_aux, data_byte, output ready);
endinterface

// ----- src/ps2mt_rsp_if.sv -----
// Response channel: position, queue status and the popped event.
interface ps2mt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ps2mt_pkg::COORD_BITS-1:0]  pos_x;
   logic [ps2mt_pkg::COORD_BITS-1:0]  pos_y;
   logic                              has_event;
   logic                              event_valid;
   logic [7:0]                        event_status;
   logic signed [7:0]                 event_dx;
   logic signed [7:0]                 event_dy;

   modport source (output valid, pos_x, pos_y, has_event, event_valid, event_status,
                   event_dx, event_dy, input ready);
   modport sink   (input valid, pos_x, pos_y, has_event, event_valid, event_status,
                   event_dx, event_dy, output ready);
endinterface

// ----- src/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker.
//
// The tracker takes one request beat per cycle while ready is high: a byte
// read from the PS/2 controller or a request to pop one queued mouse event,
// and returns exactly one response beat per request, in order. Aux bytes are
// put together into three-byte packets (status, dx, dy) while the enabled
// register is set; a first byte without bit 3 set is discarded, and a packet
// with an overflow bit in its status is dropped. A good packet adds dx to and
// subtracts dy from the absolute position, which is clamped to zero and to
// max_x and max_y, and is then stored in an event ring of QUEUE_DEPTH slots
// that holds QUEUE_DEPTH-1 events; when the ring is full the packet still
// moves the position but is not stored. Each response carries the position,
// whether the ring holds an event, and the popped event, which reads as zero
// when nothing was popped. The front end decodes request beats into commands
// and passes them through a two-entry command queue to the back end, which
// owns the position, the ring pointers, the event RAM and the response
// register. The sustained rate is one request per cycle while the response
// side keeps ready high; each request passes through the command queue and
// the response register, and a stalled response side backs up into the
// command queue before the request side sees ready drop. The event RAM
// needs no clearing after reset: only entries that were written are ever
// read. Configuration registers are written through csr_we, csr_index and
// csr_wdata and should only change while no request is in flight.
module ps2_mouse_packet_tracker #(
   parameter int QUEUE_DEPTH = ps2mt_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ps2mt_req_if.sink                            req_chan,
   ps2mt_rsp_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW = ps2mt_pkg::COORD_BITS;

   ps2mt_pkg::cfg_type cfg_ff, cfg_in;
   ps2mt_pkg::cmd_type front_cmd, back_cmd;
   logic               front_valid, front_ready;
   logic               back_valid, back_ready;

   // Configuration registers. Writes to an index beyond the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ps2mt_pkg::CSR_ENABLED: cfg_in.enabled = csr_wdata[0];
            ps2mt_pkg::CSR_MAX_X:   cfg_in.max_x   = csr_wdata[CW-1:0];
            ps2mt_pkg::CSR_MAX_Y:   cfg_in.max_y   = csr_wdata[CW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled <= 1'b0;
         cfg_ff.max_x   <= ps2mt_pkg::MAX_X_RESET;
         cfg_ff.max_y   <= ps2mt_pkg::MAX_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end keeps the packet assembly state and turns every request
   // beat into a command: no-op, pop or push.
   ps2mt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enabled   (cfg_ff.enabled),
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   ps2mt_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   // The back end executes one command per cycle whenever its response
   // register is free or being emptied.
   ps2mt_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- src/ps2mt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ps2mt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ps2mt_front.sv -----
// Front end: accepts request beats, assembles packets and issues commands.
module ps2mt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                enabled,
   ps2mt_req_if.sink           req_chan,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output ps2mt_pkg::cmd_type  cmd
);

   localparam logic [1:0] BYTE_STATUS = 2'd0;
   localparam logic [1:0] BYTE_DX     = 2'd1;
   localparam logic [1:0] BYTE_DY     = 2'd2;

   logic [1:0]          byte_index_ff, byte_index_in;
   ps2mt_pkg::byte_type held_status_ff, held_status_in;
   ps2mt_pkg::byte_type held_dx_ff, held_dx_in;
   logic                accept;

   assign req_chan.ready = cmd_ready;
   assign cmd_valid      = req_chan.valid;
   assign accept         = req_chan.valid && cmd_ready;

   always_comb begin
      byte_index_in  = byte_index_ff;
      held_status_in = held_status_ff;
      held_dx_in     = held_dx_ff;
      cmd.op         = ps2mt_pkg::OP_NOP;
      cmd.status     = held_status_ff;
      cmd.dx         = held_dx_ff;
      cmd.dy         = req_chan.data_byte;

      if (req_chan.req_type == ps2mt_pkg::REQ_POP) begin
         cmd.op = ps2mt_pkg::OP_POP;
      end else if (req_chan.from_aux && enabled && accept) begin
         case (byte_index_ff)
            BYTE_STATUS: begin
               // A first byte without the sync bit is thrown away.
               if (req_chan.data_byte[ps2mt_pkg::STATUS_SYNC_BIT]) begin
                  held_status_in = req_chan.data_byte;
                  byte_index_in  = BYTE_DX;
               end
            end
            BYTE_DX: begin
               held_dx_in    = req_chan.data_byte;
               byte_index_in = BYTE_DY;
            end
            default: begin
               byte_index_in = BYTE_STATUS;
               if (!held_status_ff[ps2mt_pkg::STATUS_X_OVF_BIT] &&
                   !held_status_ff[ps2mt_pkg::STATUS_Y_OVF_BIT]) begin
                  cmd.op = ps2mt_pkg::OP_PUSH;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= BYTE_STATUS;
         held_status_ff <= '0;
         held_dx_ff     <= '0;
      end else if (accept) begin
         byte_index_ff  <= byte_index_in;
         held_status_ff <= held_status_in;
         held_dx_ff     <= held_dx_in;
      end
   end

endmodule

// ----- src/ps2mt_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
module ps2mt_cmd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ps2mt_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ps2mt_pkg::cmd_type  pop_cmd
);

   localparam int DEPTH = ps2mt_pkg::CMDQ_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ps2mt_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- src/ps2mt_back.sv -----
// Back end: moves the position, runs the event ring and holds the response.
module ps2mt_back #(
   parameter int QUEUE_DEPTH = ps2mt_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  ps2mt_pkg::cfg_type  cfg,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  ps2mt_pkg::cmd_type  cmd,
   ps2mt_rsp_if.source         rsp_chan
);

   localparam int CW    = ps2mt_pkg::COORD_BITS;
   localparam int SW    = CW + 2;
   localparam int SEXT  = SW - 8;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int EW    = ps2mt_pkg::EVENT_BITS;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   function automatic logic [CW-1:0] clamp_coord(input logic signed [SW-1:0] v,
                                                 input logic [CW-1:0]        maxv);
      if (v[SW-1]) begin
         return '0;
      end else if (v[CW:0] > {1'b0, maxv}) begin
         return maxv;
      end else begin
         return v[CW-1:0];
      end
   endfunction

   logic [CW-1:0]    cur_x_ff, cur_x_in;
   logic [CW-1:0]    cur_y_ff, cur_y_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             out_valid_ff, out_valid_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic signed [SW-1:0] sum_x, sum_y;
   logic             fire, ram_wr_en, ram_rd_en;
   logic [EW-1:0]    ram_rd_data;

   assign cmd_ready = !out_valid_ff || rsp_chan.ready;
   assign fire      = cmd_valid && cmd_ready;

   assign wr_next = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);

   assign sum_x = $signed({2'b00, cur_x_ff}) + $signed({{SEXT{cmd.dx[7]}}, cmd.dx});
   assign sum_y = $signed({2'b00, cur_y_ff}) - $signed({{SEXT{cmd.dy[7]}}, cmd.dy});

   assign ram_wr_en = fire && (cmd.op == ps2mt_pkg::OP_PUSH) && (wr_next != rd_ptr_ff);
   assign ram_rd_en = fire && (cmd.op == ps2mt_pkg::OP_POP) && (wr_ptr_ff != rd_ptr_ff);

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      ev_valid_in  = ev_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         ev_valid_in  = ram_rd_en;
         case (cmd.op)
            ps2mt_pkg::OP_PUSH: begin
               cur_x_in = clamp_coord(sum_x, cfg.max_x);
               cur_y_in = clamp_coord(sum_y, cfg.max_y);
               if (ram_wr_en) begin
                  wr_ptr_in = wr_next;
               end
            end
            ps2mt_pkg::OP_POP: begin
               if (ram_rd_en) begin
                  rd_ptr_in = rd_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= ps2mt_pkg::POS_X_RESET;
         cur_y_ff     <= ps2mt_pkg::POS_Y_RESET;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_valid_ff <= 1'b0;
         ev_valid_ff  <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_valid_ff <= out_valid_in;
         ev_valid_ff  <= ev_valid_in;
      end
   end

   ps2mt_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data ({cmd.dy, cmd.dx, cmd.status}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Position and pointers only move when a new response is loaded, so they
   // describe the response that is on display.
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.pos_x        = cur_x_ff;
   assign rsp_chan.pos_y        = cur_y_ff;
   assign rsp_chan.has_event    = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_chan.event_valid  = ev_valid_ff;
   assign rsp_chan.event_status = ev_valid_ff ? ram_rd_data[7:0] : 8'h00;
   assign rsp_chan.event_dx     = ev_valid_ff ? $signed(ram_rd_data[15:8]) : 8'sh00;
   assign rsp_chan.event_dy     = ev_valid_ff ? $signed(ram_rd_data[23:16]) : 8'sh00;

endmodule

// ----- src/ps2mt_checker.sv -----
// Port-level checks of the PS/2 mouse packet tracker, bound to the top level.
module ps2mt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ps2mt_pkg::COORD_BITS-1:0] rsp_pos_x,
   input logic [ps2mt_pkg::COORD_BITS-1:0] rsp_pos_y,
   input logic                             rsp_has_event,
   input logic                             rsp_event_valid,
   input logic [7:0]                       rsp_event_status,
   input logic [7:0]                       rsp_event_dx,
   input logic [7:0]                       rsp_event_dy
);

   // A response that is held back keeps all of its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
         $stable(rsp_has_event) && $stable(rsp_event_valid) &&
         $stable(rsp_event_status) && $stable(rsp_event_dx) && $stable(rsp_event_dy))
      else $error("held response changed");

   // Without a popped event the event fields read as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |->
         rsp_event_status == 8'h00 && rsp_event_dx == 8'h00 && rsp_event_dy == 8'h00)
      else $error("event fields not zero without an event");

   // Reset empties the response side.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Reset empties the command queue, so requests are taken right away.
   assert property (@(posedge clock) $past(reset) |-> req_ready)
      else $error("request not ready right after reset");

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pos_x        (rsp_chan.pos_x),
   .rsp_pos_y        (rsp_chan.pos_y),
   .rsp_has_event    (rsp_chan.has_event),
   .rsp_event_valid  (rsp_chan.event_valid),
   .rsp_event_status (rsp_chan.event_status),
   .rsp_event_dx     (rsp_chan.event_dx),
   .rsp_event_dy     (rsp_chan.event_dy)
);

// ----- tb/ps2_mouse_packet_tracker_tb.sv -----
// Self-checking testbench for the PS/2 mouse packet tracker.
module ps2_mouse_packet_tracker_tb;
   import ps2mt_pkg::*;

   // Timing of the run. The limit is far beyond the slowest correct run.
   localparam int  RESET_CYCLES      = 7;
   localparam int  SETTLE_CYCLES     = 6;
   localparam int  LONG_HOLD_CYCLES  = 150;
   localparam int  MAX_SHOWN         = 10;
   localparam time RUN_LIMIT         = 400000 * 10;

   // Random phases. A maximum of -1 means a random limit is picked for the phase.
   // Drift 1 pushes the position up and right, drift 2 down and left.
   localparam int NUM_PHASES = 10;
   localparam int HOLD_PHASE = 8;
   localparam int PHASE_ENABLED [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1};
   localparam int PHASE_MAX_X   [NUM_PHASES] = '{1023, 1023, 1023, 0, 4095, 200, 1023, -1, -1, 4095};
   localparam int PHASE_MAX_Y   [NUM_PHASES] = '{767, 767, 767, 0, 4095, 150, 767, -1, -1, 4095};
   localparam int PHASE_BEATS   [NUM_PHASES] = '{150, 130, 100, 80, 200, 60, 20, 150, 150, 100};
   localparam int PHASE_POP_PCT [NUM_PHASES] = '{30, 0, 80, 30, 15, 40, 30, 30, 25, 30};
   localparam int PHASE_DRIFT   [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 2, 0, 2};

   // One response beat as the tracker reports it.
   typedef struct {
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic                  has_event;
      logic                  event_valid;
      logic [7:0]            event_status;
      logic signed [7:0]     event_dx;
      logic signed [7:0]     event_dy;
   } mouse_report_t;

   // The ledger keeps its own copy of the tracker: the packet assembler, the
   // position, the event ring and the limits. Every accepted request beat is
   // played against it, and the report that beat must produce is queued until
   // the matching response beat comes back.
   class report_ledger;
      logic                  enabled;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] max_y;
      logic [1:0]            byte_idx;
      byte_type              held_status;
      byte_type              held_dx;
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [EVENT_BITS-1:0] event_ring [QUEUE_DEPTH];
      int                    wr_ptr;
      int                    rd_ptr;
      mouse_report_t         awaited_reports [$];
      int                    mismatches;

      function new();
         enabled     = 1'b0;
         max_x       = MAX_X_RESET;
         max_y       = MAX_Y_RESET;
         byte_idx    = 2'd0;
         held_status = '0;
         held_dx     = '0;
         cur_x       = POS_X_RESET;
         cur_y       = POS_Y_RESET;
         wr_ptr      = 0;
         rd_ptr      = 0;
         mismatches  = 0;
      endfunction

      function int ring_next(int p);
         return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
      endfunction

      function logic [COORD_BITS-1:0] clamp_coord(int v, logic [COORD_BITS-1:0] lim);
         if (v < 0) v = 0;
         if (v > int'(lim)) return lim;
         return COORD_BITS'(v);
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_ENABLED: enabled = val[0];
            CSR_MAX_X: max_x = val[COORD_BITS-1:0];
            CSR_MAX_Y: max_y = val[COORD_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [1:0] packet_phase();
         return byte_idx;
      endfunction

      function int pending();
         return awaited_reports.size();
      endfunction

      function void note_request(logic kind, logic aux, byte_type data);
         mouse_report_t r;
         int            nx;
         int            ny;
         int            next_wr;
         r = '{default: '0};
         if (kind == REQ_BYTE) begin
            if (aux && enabled) begin
               case (byte_idx)
                  2'd0: begin
                     if (data[STATUS_SYNC_BIT]) begin
                        held_status = data;
                        byte_idx    = 2'd1;
                     end
                  end
                  2'd1: begin
                     held_dx  = data;
                     byte_idx = 2'd2;
                  end
                  default: begin
                     byte_idx = 2'd0;
                     if (!held_status[STATUS_X_OVF_BIT] && !held_status[STATUS_Y_OVF_BIT]) begin
                        nx    = int'(cur_x) + int'($signed(held_dx));
                        ny    = int'(cur_y) - int'($signed(data));
                        cur_x = clamp_coord(nx, max_x);
                        cur_y = clamp_coord(ny, max_y);
                        next_wr = ring_next(wr_ptr);
                        // A full ring still lets the packet move the pointer on screen.
                        if (next_wr != rd_ptr) begin
                           event_ring[wr_ptr] = {data, held_dx, held_status};
                           wr_ptr = next_wr;
                        end
                     end
                  end
               endcase
            end
         end else if (wr_ptr != rd_ptr) begin
            r.event_valid = 1'b1;
            {r.event_dy, r.event_dx, r.event_status} = event_ring[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
         end
         r.pos_x     = cur_x;
         r.pos_y     = cur_y;
         r.has_event = (wr_ptr != rd_ptr);
         awaited_reports.push_back(r);
      endfunction

      function string show(mouse_report_t r);
         return $sformatf("pos %0d,%0d has_event %b event %b status %02h dx %0d dy %0d",
                          r.pos_x, r.pos_y, r.has_event, r.event_valid, r.event_status,
                          r.event_dx, r.event_dy);
      endfunction

      function void check_report(mouse_report_t got);
         mouse_report_t want;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected response beat: %s", show(got));
            return;
         end
         want = awaited_reports.pop_front();
         if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
             got.has_event !== want.has_event || got.event_valid !== want.event_valid ||
             got.event_status !== want.event_status || got.event_dx !== want.event_dx ||
             got.event_dy !== want.event_dy) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("response mismatch at %0t", $time);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   ps2mt_req_if req_bus ();
   ps2mt_rsp_if rsp_bus ();

   ps2_mouse_packet_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   report_ledger book;

   // The sender tracks the enabled register so that it can tell which bytes
   // the tracker is going to ignore; those do not count toward a phase.
   logic enabled_now     = 1'b0;
   int   useful_beats    = 0;
   int   burst_left      = 1;
   bit   start_long_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hang anywhere ends the run here.
   initial begin
      #(RUN_LIMIT);
      $display("** ps2_mouse_packet_tracker: FAILED **");
      $finish;
   end

   // Offers one request beat and holds it until the tracker takes it. The
   // sender works in bursts; when a burst runs out, valid drops for a random
   // gap. Valid is never lowered and raised again in the same time step, since
   // the next beat simply keeps it high.
   task automatic send_beat(logic kind, logic aux, byte_type data);
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.from_aux  <= aux;
      req_bus.data_byte <= data;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      book.note_request(kind, aux, data);
      if (kind == REQ_POP || (aux && enabled_now)) useful_beats++;
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(10, 60);
      end
   endtask

   task automatic send_pop();
      send_beat(REQ_POP, 1'($urandom_range(0, 1)), 8'($urandom));
   endtask

   task automatic send_packet(byte_type status, byte_type dx, byte_type dy);
      send_beat(REQ_BYTE, 1'b1, status);
      send_beat(REQ_BYTE, 1'b1, dx);
      send_beat(REQ_BYTE, 1'b1, dy);
   endtask

   // Completes any packet left half done by a stray byte, so that the next
   // packet starts on a status byte. With the tracker disabled nothing moves,
   // so there is nothing to complete.
   task automatic realign();
      if (enabled_now) begin
         while (book.packet_phase() != 2'd0) send_beat(REQ_BYTE, 1'b1, 8'($urandom));
      end
   endtask

   // Stops offering beats and waits until every response has come back, then
   // lets the pipeline settle so that a stray extra response would be seen.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back; only called while idle.
   task automatic apply_config(logic en, logic [COORD_BITS-1:0] mx, logic [COORD_BITS-1:0] my);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENABLED;
      csr_wdata <= CSR_DATA_BITS'(en);
      @(posedge clock);
      book.write_reg(CSR_ENABLED, CSR_DATA_BITS'(en));
      csr_index <= CSR_MAX_X;
      csr_wdata <= CSR_DATA_BITS'(mx);
      @(posedge clock);
      book.write_reg(CSR_MAX_X, CSR_DATA_BITS'(mx));
      csr_index <= CSR_MAX_Y;
      csr_wdata <= CSR_DATA_BITS'(my);
      @(posedge clock);
      book.write_reg(CSR_MAX_Y, CSR_DATA_BITS'(my));
      csr_we      <= 1'b0;
      enabled_now  = en;
   endtask

   // Random traffic for one phase. Apart from the pops, most units are well
   // formed packets with random content; the rest are noise: bytes without the
   // aux flag, first bytes missing the sync bit, packets with overflow bits
   // and single stray bytes that break the packet framing.
   task automatic run_random(int goal, int pop_pct, int drift);
      int       start;
      int       pick;
      byte_type status;
      byte_type dx;
      byte_type dy;
      start = useful_beats;
      while (useful_beats - start < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < pop_pct) begin
            send_pop();
         end else if (pick < pop_pct + (100 - pop_pct) * 85 / 100) begin
            status = 8'($urandom);
            status[STATUS_SYNC_BIT]  = 1'b1;
            status[STATUS_X_OVF_BIT] = 1'b0;
            status[STATUS_Y_OVF_BIT] = 1'b0;
            case (drift)
               1: begin
                  dx = 8'($urandom_range(64, 127));
                  dy = 8'(256 - $urandom_range(64, 128));
               end
               2: begin
                  dx = 8'(256 - $urandom_range(64, 128));
                  dy = 8'($urandom_range(64, 127));
               end
               default: begin
                  dx = 8'($urandom);
                  dy = 8'($urandom);
               end
            endcase
            realign();
            send_packet(status, dx, dy);
         end else begin
            case ($urandom_range(0, 3))
               0: send_beat(REQ_BYTE, 1'b0, 8'($urandom));
               1: begin
                  status = 8'($urandom);
                  status[STATUS_SYNC_BIT] = 1'b0;
                  realign();
                  send_beat(REQ_BYTE, 1'b1, status);
               end
               2: begin
                  status = 8'($urandom);
                  status[STATUS_SYNC_BIT] = 1'b1;
                  status[STATUS_Y_OVF_BIT:STATUS_X_OVF_BIT] = 2'($urandom_range(1, 3));
                  realign();
                  send_packet(status, 8'($urandom), 8'($urandom));
               end
               default: send_beat(REQ_BYTE, 1'b1, 8'($urandom));
            endcase
         end
      end
   endtask

   // Response side. Every accepted response beat is checked against the
   // oldest awaited report. Ready follows a stall pattern that is picked anew
   // at random: always ready, ready three quarters of the time, ready half of
   // the time at random, or ready only now and then. Once in the run a long
   // hold keeps ready low while the sender keeps offering beats, so that the
   // tracker backs up and drops its own ready.
   initial begin : response_side
      mouse_report_t got;
      int            cyc;
      int            mode;
      int            hold_left;
      cyc       = 0;
      mode      = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.pos_x        = rsp_bus.pos_x;
            got.pos_y        = rsp_bus.pos_y;
            got.has_event    = rsp_bus.has_event;
            got.event_valid  = rsp_bus.event_valid;
            got.event_status = rsp_bus.event_status;
            got.event_dx     = rsp_bus.event_dx;
            got.event_dy     = rsp_bus.event_dy;
            book.check_report(got);
         end
         if (start_long_hold) begin
            hold_left       = LONG_HOLD_CYCLES;
            start_long_hold = 1'b0;
         end
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         cyc++;
         if (reset || hold_left > 0) begin
            if (hold_left > 0) hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= (cyc % 4 != 3);
               2: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Request side and the overall sequence of the run.
   initial begin : request_side
      int mx;
      int my;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = REQ_BYTE;
      req_bus.from_aux  = 1'b0;
      req_bus.data_byte = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_ENABLED;
      csr_wdata         = '0;
      reset             = 1'b1;
      book = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset the tracker is disabled: a good status byte is
      // ignored and a pop finds the ring empty.
      send_beat(REQ_BYTE, 1'b1, 8'h08);
      send_beat(REQ_POP, 1'b0, 8'h00);
      drain_responses();
      apply_config(1'b1, MAX_X_RESET, MAX_Y_RESET);

      // Directed beats: a byte without the aux flag, first bytes without the
      // sync bit (all other bits clear, then all other bits set), a pop from
      // the empty ring, the largest deltas both ways, packets with each
      // overflow bit, and pops that carry aux and data that must be ignored.
      send_beat(REQ_BYTE, 1'b0, 8'h08);
      send_beat(REQ_BYTE, 1'b1, 8'h00);
      send_beat(REQ_BYTE, 1'b1, 8'hF7);
      send_beat(REQ_POP, 1'b0, 8'h00);
      send_packet(8'h08, 8'h7F, 8'h80);
      send_packet(8'h48, 8'h01, 8'h01);
      send_packet(8'h88, 8'hFF, 8'hFF);
      send_packet(8'h3F, 8'h80, 8'h7F);
      send_beat(REQ_POP, 1'b1, 8'hFF);
      send_beat(REQ_POP, 1'b0, 8'h55);
      send_beat(REQ_POP, 1'b1, 8'hAA);

      // Random phases. The ring is filled past its limit with no pops, then
      // drained down to empty pops; the limits swing between zero, the top
      // of the range and values below the current position, and one phase
      // runs with the tracker disabled. Each phase starts only after all
      // responses of the previous one have come back.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_responses();
         mx = (PHASE_MAX_X[p] < 0) ? $urandom_range(0, 4095) : PHASE_MAX_X[p];
         my = (PHASE_MAX_Y[p] < 0) ? $urandom_range(0, 4095) : PHASE_MAX_Y[p];
         apply_config(1'(PHASE_ENABLED[p]), COORD_BITS'(mx), COORD_BITS'(my));
         if (p == HOLD_PHASE) start_long_hold = 1'b1;
         run_random(PHASE_BEATS[p], PHASE_POP_PCT[p], PHASE_DRIFT[p]);
      end
      drain_responses();

      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("** ps2_mouse_packet_tracker: PASSED **");
      end else begin
         $display("** ps2_mouse_packet_tracker: FAILED **");
      end
      $finish;
   end

endmodule
